### hw/rtl/rtm_pkg.sv
`default_nettype none

package rtm_pkg;

    localparam int unsigned MaxRanges = 1024;
    localparam int unsigned IdxW      = $clog2(MaxRanges);
    localparam int unsigned CntW      = IdxW + 1;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_BUILD  = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NOT_BUILT = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } t_rng;

    // ins: sorted insert of the key, rot: shift toward cell 0 with wrap,
    // wr: load write data into the cell whose index matches the write position
    typedef struct packed {
        logic ins;
        logic rot;
        logic wr;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/rtm_if.sv
`default_nettype none

interface rtm_in_if import rtm_pkg::*; ;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [31:0] query_address;

    modport source (output valid, output func, output range_low, output range_high,
                    output query_address, input ready);
    modport sink   (input valid, input func, input range_low, input range_high,
                    input query_address, output ready);
endinterface

interface rtm_out_if import rtm_pkg::*; ;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  entry_index;
    logic [31:0] match_low;
    logic [31:0] match_high;
    logic [10:0] entry_total;
    logic [9:0]  merged_total;

    modport source (output valid, output status, output entry_index, output match_low,
                    output match_high, output entry_total, output merged_total,
                    input ready);
    modport sink   (input valid, input status, input entry_index, input match_low,
                    input match_high, input entry_total, input merged_total,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/rtm_cell.sv
`default_nettype none

module rtm_cell import rtm_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic [IdxW-1:0] i_idx,
    input  wire t_cell_ctl       i_ctl,
    input  wire logic [CntW-1:0] i_count,
    input  wire t_rng            i_key,
    input  wire t_rng            i_left,
    input  wire logic            i_left_ins,
    input  wire t_rng            i_right,
    input  wire logic [IdxW-1:0] i_wpos,
    input  wire t_rng            i_wdata,
    output t_rng                 o_rng,
    output logic                 o_ins
);

    t_rng r_rng;
    t_rng n_rng;
    logic w_valid;
    logic w_key_lt;

    assign w_valid  = {1'b0, i_idx} < i_count;
    assign w_key_lt = (i_key.lo < r_rng.lo) ||
                      ((i_key.lo == r_rng.lo) && (i_key.hi < r_rng.hi));
    assign o_ins    = w_valid && w_key_lt;
    assign o_rng    = r_rng;

    always_comb begin
        n_rng = r_rng;
        if (i_ctl.wr && (i_wpos == i_idx)) begin
            n_rng = i_wdata;
        end else if (i_ctl.rot) begin
            n_rng = i_right;
        end else if (i_ctl.ins && (!w_valid || w_key_lt)) begin
            // key lands here, or the larger neighbor slides up one place
            n_rng = i_left_ins ? i_left : i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rng <= n_rng;
    end

endmodule

`default_nettype wire

### hw/rtl/ip_range_table_merge_lookup_core.sv
`default_nettype none

// Range table built as a chain of 1024 cells, each holding one range. The
// chain is kept sorted by low bound as ranges are appended, so a build is
// only the merge pass. Append, lookup of an unbuilt table and the unused
// function answer straight from idle through the output register. Build
// rotates the whole chain once past the merge unit at cell 0 and writes
// merged ranges back in place. Lookup rotates the chain once past a
// compare at cell 0. Both passes read every cell through the one head point.
// A new word is taken once the previous result has left the output register.
module ip_range_table_merge_lookup_core import rtm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rtm_in_if.sink    i_in,
    rtm_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BUILD = 5'b00010,
        S_BFIN  = 5'b00100,
        S_LOOK  = 5'b01000,
        S_SPARE = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic            r_built, n_built;
    logic [IdxW-1:0] r_k, n_k;
    logic [IdxW-1:0] r_w, n_w;
    logic [IdxW-1:0] r_absorbed, n_absorbed;
    t_rng            r_acc, n_acc;
    logic            r_found, n_found;
    logic [31:0]     r_query, n_query;
    logic            r_ovalid, n_ovalid;
    t_status         r_status, n_status;
    logic [IdxW-1:0] r_index, n_index;
    t_rng            r_match, n_match;
    logic [CntW-1:0] r_total, n_total;
    logic [IdxW-1:0] r_merged, n_merged;

    t_cell_ctl       w_ctl;
    logic [IdxW-1:0] w_wpos;
    t_rng            w_key;
    t_rng            w_rng [MaxRanges];
    logic            w_ins [MaxRanges];
    t_rng            w_head;
    logic            w_in_acc;
    logic            w_live;
    logic            w_merge;
    logic            w_hit;

    // chain of cells: insert moves data up, rotate moves it toward the head
    for (genvar g = 0; g < MaxRanges; g++) begin : g_cell
        if (g == 0) begin : g_first
            rtm_cell u_cell (
                .i_clk      (i_clk),
                .i_idx      (IdxW'(g)),
                .i_ctl      (w_ctl),
                .i_count    (r_count),
                .i_key      (w_key),
                .i_left     (w_key),
                .i_left_ins (1'b0),
                .i_right    (w_rng[(g + 1) % MaxRanges]),
                .i_wpos     (w_wpos),
                .i_wdata    (r_acc),
                .o_rng      (w_rng[g]),
                .o_ins      (w_ins[g])
            );
        end else begin : g_rest
            rtm_cell u_cell (
                .i_clk      (i_clk),
                .i_idx      (IdxW'(g)),
                .i_ctl      (w_ctl),
                .i_count    (r_count),
                .i_key      (w_key),
                .i_left     (w_rng[g - 1]),
                .i_left_ins (w_ins[g - 1]),
                .i_right    (w_rng[(g + 1) % MaxRanges]),
                .i_wpos     (w_wpos),
                .i_wdata    (r_acc),
                .o_rng      (w_rng[g]),
                .o_ins      (w_ins[g])
            );
        end
    end

    assign w_head   = w_rng[0];
    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_live   = {1'b0, r_k} < r_count;
    assign w_merge  = (r_acc.hi == 32'hFFFF_FFFF) ||
                      ({1'b0, w_head.lo} <= ({1'b0, r_acc.hi} + 33'd1));
    assign w_hit    = w_live && !r_found && (r_query >= w_head.lo) &&
                      (r_query <= w_head.hi);

    // store every range with low not above high
    always_comb begin
        if (i_in.range_high < i_in.range_low) begin
            w_key.lo = i_in.range_high;
            w_key.hi = i_in.range_low;
        end else begin
            w_key.lo = i_in.range_low;
            w_key.hi = i_in.range_high;
        end
    end

    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_built    = r_built;
        n_k        = r_k;
        n_w        = r_w;
        n_absorbed = r_absorbed;
        n_acc      = r_acc;
        n_found    = r_found;
        n_query    = r_query;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_status   = r_status;
        n_index    = r_index;
        n_match    = r_match;
        n_total    = r_total;
        n_merged   = r_merged;
        w_ctl      = '0;
        w_wpos     = r_w;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_index  = '0;
                    n_match  = '0;
                    n_merged = '0;
                    n_status = ST_OK;
                    n_ovalid = 1'b1;
                    n_k      = '0;
                    n_w      = '0;
                    case (t_func'(i_in.func))
                        FUNC_APPEND: begin
                            if (r_count == CntW'(MaxRanges)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + CntW'(1);
                                n_built   = 1'b0;
                            end
                        end
                        FUNC_BUILD: begin
                            n_ovalid   = 1'b0;
                            n_absorbed = '0;
                            n_state    = S_BUILD;
                        end
                        FUNC_LOOKUP: begin
                            if (!r_built) begin
                                n_status = ST_NOT_BUILT;
                            end else begin
                                n_ovalid = 1'b0;
                                n_found  = 1'b0;
                                n_query  = i_in.query_address;
                                n_state  = S_LOOK;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_total = n_count;
                end
            end
            S_BUILD: begin
                w_ctl.rot = 1'b1;
                // logical entry w sits at cell (w - k - 1) after this shift
                w_wpos = IdxW'({1'b0, r_w} + CntW'(MaxRanges - 1) - {1'b0, r_k});
                if (w_live) begin
                    if (r_k == '0) begin
                        n_acc = w_head;
                    end else if (w_merge) begin
                        if (w_head.hi > r_acc.hi) begin
                            n_acc.hi = w_head.hi;
                        end
                        n_absorbed = r_absorbed + IdxW'(1);
                    end else begin
                        w_ctl.wr = 1'b1;
                        n_w      = r_w + IdxW'(1);
                        n_acc    = w_head;
                    end
                end
                if (r_k == IdxW'(MaxRanges - 1)) begin
                    n_state = S_BFIN;
                end else begin
                    n_k = r_k + IdxW'(1);
                end
            end
            S_BFIN: begin
                // chain is back in place: flush the open range
                w_wpos = r_w;
                if (r_count != '0) begin
                    w_ctl.wr = 1'b1;
                    n_count  = {1'b0, r_w} + CntW'(1);
                end
                n_built  = 1'b1;
                n_status = ST_OK;
                n_total  = n_count;
                n_merged = r_absorbed;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_LOOK: begin
                w_ctl.rot = 1'b1;
                if (w_hit) begin
                    n_found = 1'b1;
                    n_w     = r_k;
                    n_acc   = w_head;
                end
                if (r_k == IdxW'(MaxRanges - 1)) begin
                    n_status = n_found ? ST_OK : ST_NOT_FOUND;
                    n_index  = n_found ? n_w : '0;
                    n_match  = n_found ? n_acc : '0;
                    n_total  = r_count;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_k = r_k + IdxW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_built  <= n_built;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_w        <= n_w;
        r_absorbed <= n_absorbed;
        r_acc      <= n_acc;
        r_query    <= n_query;
        r_status   <= n_status;
        r_index    <= n_index;
        r_match    <= n_match;
        r_total    <= n_total;
        r_merged   <= n_merged;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_status;
    assign o_out.entry_index  = r_index;
    assign o_out.match_low    = r_match.lo;
    assign o_out.match_high   = r_match.hi;
    assign o_out.entry_total  = r_total;
    assign o_out.merged_total = r_merged;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxRanges))
        else $error("range count beyond table size");

    a_append_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.func == FUNC_APPEND) && (r_count != CntW'(MaxRanges)))
        |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("append did not grow the table");

    a_look_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> r_built)
        else $error("search of an unbuilt table");

    a_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BUILD) && w_ctl.wr) |-> (r_w < r_k))
        else $error("merge write overtook the read point");

endmodule

`default_nettype wire
